// File: hdl/sss_pkg.sv
// Shared types and codes for the sorted matrix staircase search block.
package sss_pkg;

   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   // Request action codes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } fsm_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic wr_en;   // store the load beat
      logic start;   // open a search walk
      logic step;    // move down or left
      logic finish;  // capture the answer in the output register
   } sss_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic active;  // current position lies inside the area in use
      logic hit;     // current element equals the target
   } sss_status_type;

endpackage

// File: hdl/sorted_matrix_staircase_search_top.sv
// Top level of the sorted matrix staircase search block.
// Load beat: taken while idle, one load per cycle, no response.
// Search beat: the walk makes one memory read per cycle; the next request beat is
//   taken once the walk ends, later while the previous response still waits. The
//   response is valid the cycle after the walk ends.
// Reset clears both counts, the walk state and the response valid; the memory is not cleared.
module sorted_matrix_staircase_search_top #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sss_pkg::CSR_DAT_W-1:0]      csr_data,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [sss_pkg::INDEX_W-1:0]        req_row_index,
   input  logic [sss_pkg::INDEX_W-1:0]        req_column_index,
   input  logic signed [sss_pkg::VALUE_W-1:0] req_value,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found
);
   import sss_pkg::*;

   sss_cmd_type    cmd;
   sss_status_type status;

   // Take configuration beats at any time; software writes them only while idle
   assign csr_ready = 1'b1;

   // Sequence loads, searches and the response beat
   sss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the matrix, advance the walk and compare against the target
   sss_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr           (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .req_value        (req_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_found        (rsp_found)
   );

   // Never overwrite a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("response overwritten while pending");

   // Step only from a position inside the area and only on a miss
   a_step_inside: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (status.active && !status.hit))
      else $error("walk stepped outside the area or past a hit");

   // A search beat blocks further request beats until its walk ends
   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_ready)
      else $error("request accepted during a search walk");

   // A finished walk always raises the response valid
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished walk produced no response");

endmodule

// File: hdl/sss_ctrl.sv
// Controller state machine for the staircase search: sequencing and handshakes.
module sss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sss_pkg::sss_status_type status,
   output sss_pkg::sss_cmd_type    cmd
);
   import sss_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          walk_end;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign walk_end = !status.active || status.hit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_action == ACT_SEARCH) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_end && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.wr_en  = 1'b0;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.wr_en = req_valid && req_action == ACT_LOAD;
            cmd.start = req_valid && req_action == ACT_SEARCH;
         end
         ST_WALK: begin
            cmd.step   = !walk_end;
            cmd.finish = walk_end && out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/sss_datapath.sv
// Datapath for the staircase search: matrix memory, walk position and compare.
module sss_datapath #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr,
   input  logic [sss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sss_pkg::CSR_DAT_W-1:0]    csr_data,
   input  logic [sss_pkg::INDEX_W-1:0]      req_row_index,
   input  logic [sss_pkg::INDEX_W-1:0]      req_column_index,
   input  logic signed [sss_pkg::VALUE_W-1:0] req_value,
   input  sss_pkg::sss_cmd_type              cmd,
   output sss_pkg::sss_status_type           status,
   output logic                             rsp_found
);
   import sss_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLUMNS + 1);
   localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [VALUE_W-1:0] mem [DEPTH];

   logic [RW-1:0]             row_lim_ff, row_lim_in;
   logic [CW-1:0]             col_lim_ff, col_lim_in;
   logic [RW-1:0]             r_ff, r_in;
   logic [CW-1:0]             left_ff, left_in;
   logic signed [VALUE_W-1:0] target_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      found_ff;
   logic                      wr_ok;
   logic                      next_ok;
   logic                      rd_en;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;

   // Saturate the counts to the array size
   always_comb begin
      row_lim_in = row_lim_ff;
      col_lim_in = col_lim_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_ROW_COUNT: begin
               row_lim_in = (32'(csr_data) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(csr_data);
            end
            CSR_COLUMN_COUNT: begin
               col_lim_in = (32'(csr_data) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(csr_data);
            end
            default: begin
               row_lim_in = row_lim_ff;
            end
         endcase
      end
   end

   // Walk position: current element sits at row r, column left - 1
   always_comb begin
      r_in    = r_ff;
      left_in = left_ff;
      if (cmd.start) begin
         r_in    = '0;
         left_in = col_lim_ff;
      end else if (cmd.step) begin
         if (target_ff > rd_data_ff) begin
            r_in = RW'(r_ff + 1'b1);
         end else begin
            left_in = CW'(left_ff - 1'b1);
         end
      end
   end

   assign status.active = (r_ff < row_lim_ff) && (left_ff != '0);
   assign status.hit    = (rd_data_ff == target_ff);

   assign next_ok = (r_in < row_lim_in) && (left_in != '0);
   assign rd_en   = (cmd.start || cmd.step) && next_ok;
   assign rd_addr = AW'(int'(r_in) * MAX_COLUMNS + int'(left_in) - 1);

   assign wr_ok   = (32'(req_row_index) < MAX_ROWS) && (32'(req_column_index) < MAX_COLUMNS);
   assign wr_addr = AW'(int'(req_row_index) * MAX_COLUMNS + int'(req_column_index));

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_lim_ff <= '0;
         col_lim_ff <= '0;
         r_ff       <= '0;
         left_ff    <= '0;
      end else begin
         row_lim_ff <= row_lim_in;
         col_lim_ff <= col_lim_in;
         r_ff       <= r_in;
         left_ff    <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         target_ff <= req_value;
      end
      if (cmd.finish) begin
         found_ff <= status.active && status.hit;
      end
   end

   assign rsp_found = found_ff;

endmodule

// File: tb/sv/sorted_matrix_staircase_search_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted matrix staircase search block.
module sorted_matrix_staircase_search_top_test;
   import sss_pkg::*;

   localparam int MAX_ROWS      = 64;
   localparam int MAX_COLUMNS   = 64;
   localparam int ITEM_TARGET   = 1900;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic                        clock            = 1'b0;
   logic                        reset            = 1'b1;
   logic                        csr_valid        = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index        = '0;
   logic [CSR_DAT_W-1:0]        csr_data         = '0;
   logic                        req_valid        = 1'b0;
   logic                        req_ready;
   logic                        req_action       = ACT_LOAD;
   logic [INDEX_W-1:0]          req_row_index    = '0;
   logic [INDEX_W-1:0]          req_column_index = '0;
   logic signed [VALUE_W-1:0]   req_value        = '0;
   logic                        rsp_valid;
   logic                        rsp_ready        = 1'b0;
   logic                        rsp_found;

   // Shadow of the matrix memory and the two count registers. The written
   // flags keep every search away from elements that were never loaded.
   logic signed [VALUE_W-1:0]   grid [MAX_ROWS][MAX_COLUMNS];
   bit                          grid_written [MAX_ROWS][MAX_COLUMNS];
   logic [CSR_DAT_W-1:0]        rows_reg = '0;
   logic [CSR_DAT_W-1:0]        cols_reg = '0;
   // Sorted contents planned for the current area before they are loaded.
   logic signed [VALUE_W-1:0]   sorted_plan [MAX_ROWS][MAX_COLUMNS];

   // Found flags of accepted searches, oldest first.
   bit                          pending_found [$];

   int                          error_count = 0;
   int                          items_sent  = 0;
   int unsigned                 cycle_count = 0;

   // Idling knobs and the long receiver hold-off request (toggle handshake).
   bit                          tx_gaps_on = 1'b0;
   bit                          rx_gaps_on = 1'b0;
   bit                          hold_req   = 1'b0;
   bit                          hold_ack   = 1'b0;
   int                          rx_wait    = 0;

   always #5 clock = ~clock;

   sorted_matrix_staircase_search_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found)
   );

   // Gap length: mostly short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Walk the shadow matrix from the top-right corner of the area in use.
   // Flag the walk if it would touch an element that was never loaded.
   function automatic bit predict_found(input logic signed [VALUE_W-1:0] target,
                                        output bit reads_unwritten);
      int                        r;
      int                        left;
      int                        n_rows;
      int                        n_cols;
      logic signed [VALUE_W-1:0] elem;
      // counts above the memory size saturate
      n_rows = (rows_reg > 7'(MAX_ROWS)) ? MAX_ROWS : int'(rows_reg);
      n_cols = (cols_reg > 7'(MAX_COLUMNS)) ? MAX_COLUMNS : int'(cols_reg);
      r = 0;
      left = n_cols;
      reads_unwritten = 1'b0;
      while (r < n_rows && left > 0) begin
         if (!grid_written[r][left-1]) begin
            reads_unwritten = 1'b1;
            return 1'b0;
         end
         elem = grid[r][left-1];
         if (elem == target) return 1'b1;
         if (target > elem) r++;
         else left--;
      end
      return 1'b0;
   endfunction

   // Target choice: elements of the area, near misses and extremes.
   function automatic logic signed [VALUE_W-1:0] pick_target(input int n_rows,
                                                             input int n_cols);
      int roll;
      int r;
      int c;
      roll = $urandom_range(0, 99);
      if (n_rows == 0 || n_cols == 0 || roll >= 75) begin
         case ($urandom_range(0, 5))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            3:       return -1;
            default: return $signed($urandom);
         endcase
      end
      r = $urandom_range(0, n_rows - 1);
      c = $urandom_range(0, n_cols - 1);
      // edge-only fills hold row 0 and the last column
      if (!grid_written[r][c]) begin
         if ($urandom_range(0, 1) == 1) r = 0;
         else c = n_cols - 1;
      end
      // stale contents may leave even the edges unloaded
      if (!grid_written[r][c]) return $signed($urandom);
      if (roll < 50) return grid[r][c];
      return grid[r][c] + (($urandom_range(0, 1) == 1) ? 1 : -1);
   endfunction

   // Cycle limit: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   <= 0;
      end else if (hold_ack != hold_req) begin
         hold_ack  <= hold_req;
         rsp_ready <= 1'b0;
         rx_wait   <= HOLD_CYCLES;
      end else if (rx_wait != 0) begin
         rsp_ready <= 1'b0;
         rx_wait   <= rx_wait - 1;
      end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rx_wait   <= pick_gap() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Response check: match every response beat against the oldest search.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_found.size() == 0) begin
            error_count++;
            $display("%0t: response with no search outstanding: expected none, actual found=%b",
                     $time, rsp_found);
         end else begin
            if (rsp_found !== pending_found[0]) begin
               error_count++;
               $display("%0t: found mismatch: expected %b, actual %b",
                        $time, pending_found[0], rsp_found);
            end
            pending_found.delete(0);
         end
      end
   end

   // Offer one request beat and hold it until accepted. Keep valid high
   // across back-to-back beats; drop it only for a gap.
   task automatic send_item(input logic act, input logic [INDEX_W-1:0] row,
                            input logic [INDEX_W-1:0] col,
                            input logic signed [VALUE_W-1:0] val);
      int gap;
      gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_row_index    <= row;
      req_column_index <= col;
      req_value        <= val;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic load_cell(input logic [INDEX_W-1:0] row,
                            input logic [INDEX_W-1:0] col,
                            input logic signed [VALUE_W-1:0] val);
      send_item(ACT_LOAD, row, col, val);
      grid[row][col]         = val;
      grid_written[row][col] = 1'b1;
   endtask

   // Search for a target; fall back to the largest value (walks only the last
   // column) if the walk would hit an unloaded element.
   task automatic search_for(input logic signed [VALUE_W-1:0] target);
      bit                        want;
      bit                        unsafe;
      logic signed [VALUE_W-1:0] goal;
      goal = target;
      want = predict_found(goal, unsafe);
      if (unsafe) begin
         goal = VAL_MAX;
         want = predict_found(goal, unsafe);
      end
      if (!unsafe) begin
         send_item(ACT_SEARCH, INDEX_W'($urandom), INDEX_W'($urandom), goal);
         pending_found.push_back(want);
      end
   endtask

   // Write both counts; only called while the block is idle.
   task automatic set_area(input logic [CSR_DAT_W-1:0] n_rows,
                           input logic [CSR_DAT_W-1:0] n_cols);
      csr_valid <= 1'b1;
      csr_index <= CSR_ROW_COUNT;
      csr_data  <= n_rows;
      do @(posedge clock); while (!csr_ready);
      rows_reg = n_rows;
      csr_index <= CSR_COLUMN_COUNT;
      csr_data  <= n_cols;
      do @(posedge clock); while (!csr_ready);
      cols_reg = n_cols;
      csr_valid <= 1'b0;
   endtask

   // Pause the sender until every search has answered, then let the walk
   // and any trailing load finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_found.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Plan an ascending matrix and load it in random order. With edges_only,
   // load just row 0 and the last column.
   task automatic fill_sorted(input int n_rows, input int n_cols, input bit edges_only);
      int     order [$];
      int     spread;
      int     pick;
      int     tmp;
      longint v;
      longint up;
      longint lf;
      case ($urandom_range(0, 3))
         0:       spread = 3;
         1:       spread = 1000;
         2:       spread = 1 << 20;
         default: spread = 1 << 28;
      endcase
      for (int r = 0; r < n_rows; r++) begin
         for (int c = 0; c < n_cols; c++) begin
            if (r == 0 && c == 0) begin
               case ($urandom_range(0, 3))
                  0:       v = longint'(VAL_MIN) + longint'($urandom_range(0, 50));
                  1:       v = longint'(VAL_MAX) - longint'($urandom_range(0, 5000));
                  2:       v = longint'(int'($urandom_range(0, 200)) - 100);
                  default: v = longint'($signed($urandom));
               endcase
            end else begin
               up = (r > 0) ? longint'(sorted_plan[r-1][c]) : longint'(VAL_MIN);
               lf = (c > 0) ? longint'(sorted_plan[r][c-1]) : longint'(VAL_MIN);
               v = ((up > lf) ? up : lf) + longint'($urandom_range(0, spread));
               if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
            end
            sorted_plan[r][c] = v[VALUE_W-1:0];
            if (!edges_only || r == 0 || c == n_cols - 1) order.push_back(r * MAX_COLUMNS + c);
         end
      end
      for (int i = order.size() - 1; i > 0; i--) begin
         pick = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[pick];
         order[pick] = tmp;
      end
      foreach (order[i]) begin
         load_cell(INDEX_W'(order[i] / MAX_COLUMNS), INDEX_W'(order[i] % MAX_COLUMNS),
                   sorted_plan[order[i] / MAX_COLUMNS][order[i] % MAX_COLUMNS]);
      end
   endtask

   // Empty area: counts at reset, then zero rows, then zero columns.
   task automatic test_empty_area();
      search_for(VAL_MIN);
      search_for(VAL_MAX);
      search_for(0);
      settle();
      set_area(7'd0, 7'd5);
      search_for(32'sd17);
      settle();
      set_area(7'd9, 7'd0);
      search_for(-32'sd1);
      settle();
   endtask

   // Small hand-built matrix: hits at every corner and the middle, misses in
   // gaps and next to both extremes, then an unsorted overwrite.
   task automatic test_corner_cases();
      logic signed [VALUE_W-1:0] demo [3][3];
      demo = '{'{VAL_MIN, -5, 0}, '{-4, 1, 7}, '{2, 9, VAL_MAX}};
      set_area(7'd3, 7'd3);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            load_cell(INDEX_W'(r), INDEX_W'(c), demo[r][c]);
      search_for(0);
      search_for(VAL_MIN);
      search_for(VAL_MAX);
      search_for(2);
      search_for(1);
      search_for(3);
      search_for(VAL_MIN + 1);
      search_for(VAL_MAX - 1);
      search_for(-4);
      // break the ordering in the middle; the walk rule still decides
      load_cell(INDEX_W'(1), INDEX_W'(1), 32'sd100);
      search_for(32'sd100);
      search_for(1);
      settle();
   endtask

   // Full-size area through oversized counts, then exact maxima. Only row 0
   // and the last column are loaded, which covers the longest walks.
   task automatic test_full_span();
      set_area(7'd127, 7'd100);
      fill_sorted(MAX_ROWS, MAX_COLUMNS, 1'b1);
      search_for(VAL_MAX);
      search_for(VAL_MIN);
      search_for(sorted_plan[0][0]);
      search_for(sorted_plan[MAX_ROWS-1][MAX_COLUMNS-1]);
      search_for(sorted_plan[0][31]);
      search_for(sorted_plan[40][MAX_COLUMNS-1]);
      settle();
      set_area(7'd64, 7'd64);
      search_for(VAL_MAX);
      search_for(sorted_plan[0][0] - 1);
      search_for(sorted_plan[MAX_ROWS-1][MAX_COLUMNS-1]);
      settle();
   endtask

   // Long receiver hold-off while the sender keeps offering searches, so the
   // output fills and the input stalls; then drain completely.
   task automatic test_output_stall();
      set_area(7'd4, 7'd4);
      fill_sorted(4, 4, 1'b0);
      tx_gaps_on <= 1'b0;
      rx_gaps_on <= 1'b0;
      hold_req   <= ~hold_req;
      repeat (24) search_for(pick_target(4, 4));
      settle();
   endtask

   // Random phases: pick an area, load sorted contents, then mostly searches
   // with some stray loads and pauses mixed in.
   task automatic test_random_mix();
      int                   n_r;
      int                   n_c;
      int                   n_ops;
      int                   roll;
      logic [CSR_DAT_W-1:0] row_field;
      logic [CSR_DAT_W-1:0] col_field;
      bit                   edges_only;
      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            n_r = 0;
            n_c = 0;
         end else if (roll < 80) begin
            n_r = $urandom_range(1, 8);
            n_c = $urandom_range(1, 8);
         end else if (roll < 94) begin
            n_r = $urandom_range(1, 16);
            n_c = $urandom_range(1, 16);
         end else begin
            n_r = ($urandom_range(0, 1) == 1) ? MAX_ROWS : $urandom_range(17, MAX_ROWS);
            n_c = ($urandom_range(0, 1) == 1) ? MAX_COLUMNS : $urandom_range(17, MAX_COLUMNS);
         end
         row_field = 7'(n_r);
         col_field = 7'(n_c);
         if (n_r == 0) begin
            // empty area: one count zero, the other anything
            if ($urandom_range(0, 1) == 1) col_field = 7'($urandom);
            else row_field = 7'($urandom);
            n_c = 0;
         end
         if (n_r == MAX_ROWS && $urandom_range(0, 1) == 1)
            row_field = 7'($urandom_range(MAX_ROWS + 1, 127));
         if (n_c == MAX_COLUMNS && $urandom_range(0, 1) == 1)
            col_field = 7'($urandom_range(MAX_COLUMNS + 1, 127));
         edges_only = (n_r * n_c > 256);
         tx_gaps_on <= ($urandom_range(0, 3) != 0);
         rx_gaps_on <= ($urandom_range(0, 3) != 0);
         set_area(row_field, col_field);
         // now and then search stale contents without a fresh load
         if (n_r > 0 && n_c > 0 && $urandom_range(0, 9) != 0)
            fill_sorted(n_r, n_c, edges_only);
         n_ops = $urandom_range(10, 40);
         repeat (n_ops) begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
               load_cell(INDEX_W'($urandom), INDEX_W'($urandom), $signed($urandom));
            else if (roll < 12)
               settle();
            else
               search_for(pick_target(n_r, n_c));
         end
         settle();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_area();
      test_corner_cases();
      test_full_span();
      test_output_stall();
      test_random_mix();
      settle();
      // let any stray response show up before the verdict
      repeat (MAX_ROWS + MAX_COLUMNS + SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_found.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
